FILE: hw/rtl/strided_saturating_accumulate_store_top_assert.svh
// assertion macros for the strided saturating accumulate store checker
// depends on nothing; included by the checker file only
`ifndef STRIDED_SATURATING_ACCUMULATE_STORE_TOP_ASSERT_SVH
`define STRIDED_SATURATING_ACCUMULATE_STORE_TOP_ASSERT_SVH

// same-cycle implication, reset disables
`define SAST_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset disables
`define SAST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/sast_pkg.sv
// shared types, constants and helper functions of the strided saturating accumulate store
// depends on nothing
package sast_pkg;

	localparam int unsigned FIELD_W        = 64;
	localparam int unsigned LANE_W         = 16;
	localparam int unsigned BYTE_W         = 8;
	localparam int unsigned WORD_BYTES     = 32;
	localparam int unsigned ADDR_W         = 8;
	localparam int unsigned CNT_W          = 6;
	localparam int unsigned MAX_LOOP_COUNT = 64;
	localparam int unsigned CFG_IDX_W      = 3;
	localparam int unsigned CFG_DATA_W     = 24;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ACCUMULATE_MODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_COUNTS      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_X_STEP           = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_STEP           = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FLOW_STEP        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INSTRUCTION_STEP = 3'd5;

	localparam logic signed [LANE_W-1:0] SAT_MAX = 16'sh007f;
	localparam logic signed [LANE_W-1:0] SAT_MIN = -16'sh0080;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_CALC = 2'b10
	} state_t;

	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [ADDR_W-1:0] addr_t;

	// clamp a loop count-minus-one field to the largest supported count
	function automatic cnt_t loop_limit(input cnt_t raw);
		cnt_t top_v;
		top_v = CNT_W'(MAX_LOOP_COUNT - 1);
		return (raw > top_v) ? top_v : raw;
	endfunction

	// saturate a signed 16-bit lane to a signed byte
	function automatic logic [BYTE_W-1:0] sat_byte(input logic signed [LANE_W-1:0] v);
		logic [BYTE_W-1:0] r;
		if (v > SAT_MAX) begin
			r = 8'h7f;
		end else if (v < SAT_MIN) begin
			r = 8'h80;
		end else begin
			r = v[BYTE_W-1:0];
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/sast_if.sv
// channel interfaces: lane beat input, result output and configuration write
// depends on sast_pkg
interface sast_beat_if import sast_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] lanes_0_3;
	logic [FIELD_W-1:0] lanes_4_7;
	logic [FIELD_W-1:0] lanes_8_11;
	logic [FIELD_W-1:0] lanes_12_15;
	logic [FIELD_W-1:0] lanes_16_19;
	logic [FIELD_W-1:0] lanes_20_23;
	logic [FIELD_W-1:0] lanes_24_27;
	logic [FIELD_W-1:0] lanes_28_31;

	modport source (output valid, lanes_0_3, lanes_4_7, lanes_8_11, lanes_12_15,
		lanes_16_19, lanes_20_23, lanes_24_27, lanes_28_31, input ready);
	modport sink (input valid, lanes_0_3, lanes_4_7, lanes_8_11, lanes_12_15,
		lanes_16_19, lanes_20_23, lanes_24_27, lanes_28_31, output ready);
endinterface

interface sast_result_if import sast_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [ADDR_W-1:0]  entry_address;
	logic [FIELD_W-1:0] bytes_0_7;
	logic [FIELD_W-1:0] bytes_8_15;
	logic [FIELD_W-1:0] bytes_16_23;
	logic [FIELD_W-1:0] bytes_24_31;
	logic               final_beat;

	modport source (output valid, entry_address, bytes_0_7, bytes_8_15, bytes_16_23,
		bytes_24_31, final_beat, input ready);
	modport sink (input valid, entry_address, bytes_0_7, bytes_8_15, bytes_16_23,
		bytes_24_31, final_beat, output ready);
endinterface

interface sast_cfg_if import sast_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/strided_saturating_accumulate_store_top.sv
// strided saturating accumulate store: top level with loop address generator and store
// depends on sast_pkg, sast_if (beat, result, cfg interfaces) and sast_ram
//
//  channel  | dir | transaction carries
//  ---------+-----+---------------------------------------------------------
//  beat     | in  | eight 64-bit fields of four signed 16-bit lanes each
//  result   | out | entry address, four fields of eight bytes, final beat flag
//  cfg      | in  | register index (0..5, others ignored) and write data
//
// each beat is read, then written back: the store word at the current write address
// is read at accept, then added, saturated, written back and loaded into the output
// register; the registered read data of the store ram sets this split.
// after reset the store reads as zero via per-entry valid bits; no clearing pass.
// while a result waits on the output register a new beat is still accepted and
// read; the write-back stage holds until the output register is free.
// cfg is always ready; writes are expected only while no beat is in flight.
module strided_saturating_accumulate_store_top import sast_pkg::*; #(
	parameter int unsigned LANES         = 32,
	parameter int unsigned STORE_ENTRIES = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	sast_beat_if.sink     beat,
	sast_result_if.source result,
	sast_cfg_if.sink      cfg
);

	localparam int unsigned IDX_W  = $clog2(STORE_ENTRIES);
	localparam int unsigned WORD_W = LANES * BYTE_W;
	localparam int unsigned BEAT_W = LANES * LANE_W;

	// address to store slot, worked out at elaboration (address wraps on the store depth)
	typedef logic [IDX_W-1:0] slot_lut_t [2**ADDR_W];

	function automatic slot_lut_t build_slot_lut();
		slot_lut_t lut;
		for (int a = 0; a < 2**ADDR_W; a++) begin
			lut[a] = IDX_W'(a % STORE_ENTRIES);
		end
		return lut;
	endfunction

	localparam slot_lut_t SLOT_LUT = build_slot_lut();

	// configuration registers
	logic                  acc_mode_q;
	logic [CFG_DATA_W-1:0] loop_counts_q;
	addr_t                 x_step_q;
	addr_t                 y_step_q;
	addr_t                 flow_step_q;
	addr_t                 instr_step_q;

	// loop state
	addr_t wr_addr_q, y_base_q, flow_base_q, instr_base_q;
	cnt_t  x_cnt_q, y_cnt_q, flow_cnt_q, instr_cnt_q;
	addr_t wr_addr_d, y_base_d, flow_base_d, instr_base_d;
	cnt_t  x_cnt_d, y_cnt_d, flow_cnt_d, instr_cnt_d;
	logic  end_x, end_y, end_f, end_i;

	// sequencer and first-stage payload
	state_t                   state_q;
	logic                     beat_acc;
	logic                     wb_go;
	logic [BEAT_W-1:0]        lanes_s1;
	addr_t                    addr_s1;
	logic [IDX_W-1:0]         slot_s1;
	logic                     last_s1;
	logic [WORD_BYTES*LANE_W-1:0] beat_flat;

	// store and valid bits
	logic [WORD_W-1:0]        rd_word;
	logic [WORD_W-1:0]        wr_word;
	logic [STORE_ENTRIES-1:0] valid_q;

	// output register
	logic                            out_valid_q;
	addr_t                           out_addr_q;
	logic [WORD_BYTES*BYTE_W-1:0]    out_word_q;
	logic [WORD_BYTES*BYTE_W-1:0]    out_word_d;
	logic                            out_last_q;

	assign cfg.ready  = 1'b1;
	assign beat.ready = (state_q == ST_IDLE);
	assign beat_acc   = beat.valid && beat.ready;
	// write back once the old word is in and the output register can take the result
	assign wb_go      = (state_q == ST_CALC) && (!out_valid_q || result.ready);

	assign beat_flat = {beat.lanes_28_31, beat.lanes_24_27, beat.lanes_20_23,
		beat.lanes_16_19, beat.lanes_12_15, beat.lanes_8_11, beat.lanes_4_7,
		beat.lanes_0_3};

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_mode_q    <= 1'b0;
			loop_counts_q <= '0;
			x_step_q      <= '0;
			y_step_q      <= '0;
			flow_step_q   <= '0;
			instr_step_q  <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_ACCUMULATE_MODE:  acc_mode_q    <= cfg.data[0];
				REG_LOOP_COUNTS:      loop_counts_q <= cfg.data;
				REG_X_STEP:           x_step_q      <= cfg.data[ADDR_W-1:0];
				REG_Y_STEP:           y_step_q      <= cfg.data[ADDR_W-1:0];
				REG_FLOW_STEP:        flow_step_q   <= cfg.data[ADDR_W-1:0];
				REG_INSTRUCTION_STEP: instr_step_q  <= cfg.data[ADDR_W-1:0];
				default: ;  // unused indexes are ignored
			endcase
		end
	end

	// loop end flags against the clamped limits
	assign end_x = (x_cnt_q     == loop_limit(loop_counts_q[CNT_W-1:0]));
	assign end_y = (y_cnt_q     == loop_limit(loop_counts_q[2*CNT_W-1:CNT_W]));
	assign end_f = (flow_cnt_q  == loop_limit(loop_counts_q[3*CNT_W-1:2*CNT_W]));
	assign end_i = (instr_cnt_q == loop_limit(loop_counts_q[4*CNT_W-1:3*CNT_W]));

	// nested strided loops: innermost first, bases reload downward
	always_comb begin
		wr_addr_d    = wr_addr_q;
		y_base_d     = y_base_q;
		flow_base_d  = flow_base_q;
		instr_base_d = instr_base_q;
		x_cnt_d      = x_cnt_q;
		y_cnt_d      = y_cnt_q;
		flow_cnt_d   = flow_cnt_q;
		instr_cnt_d  = instr_cnt_q;
		priority if (!end_x) begin
			x_cnt_d   = x_cnt_q + 1'b1;
			wr_addr_d = wr_addr_q + x_step_q;
		end else if (!end_y) begin
			x_cnt_d   = '0;
			y_cnt_d   = y_cnt_q + 1'b1;
			y_base_d  = y_base_q + y_step_q;
			wr_addr_d = y_base_d;
		end else if (!end_f) begin
			x_cnt_d     = '0;
			y_cnt_d     = '0;
			flow_cnt_d  = flow_cnt_q + 1'b1;
			flow_base_d = flow_base_q + flow_step_q;
			y_base_d    = flow_base_d;
			wr_addr_d   = flow_base_d;
		end else if (!end_i) begin
			x_cnt_d      = '0;
			y_cnt_d      = '0;
			flow_cnt_d   = '0;
			instr_cnt_d  = instr_cnt_q + 1'b1;
			instr_base_d = instr_base_q + instr_step_q;
			flow_base_d  = instr_base_d;
			y_base_d     = instr_base_d;
			wr_addr_d    = instr_base_d;
		end else begin
			// whole nest done: everything back to zero
			x_cnt_d      = '0;
			y_cnt_d      = '0;
			flow_cnt_d   = '0;
			instr_cnt_d  = '0;
			instr_base_d = '0;
			flow_base_d  = '0;
			y_base_d     = '0;
			wr_addr_d    = '0;
		end
	end

	// loop state moves on at each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_addr_q    <= '0;
			y_base_q     <= '0;
			flow_base_q  <= '0;
			instr_base_q <= '0;
			x_cnt_q      <= '0;
			y_cnt_q      <= '0;
			flow_cnt_q   <= '0;
			instr_cnt_q  <= '0;
		end else if (beat_acc) begin
			wr_addr_q    <= wr_addr_d;
			y_base_q     <= y_base_d;
			flow_base_q  <= flow_base_d;
			instr_base_q <= instr_base_d;
			x_cnt_q      <= x_cnt_d;
			y_cnt_q      <= y_cnt_d;
			flow_cnt_q   <= flow_cnt_d;
			instr_cnt_q  <= instr_cnt_d;
		end
	end

	// read stage: capture the beat, its address and the last flag
	always_ff @(posedge clk) begin
		if (beat_acc) begin
			lanes_s1 <= beat_flat[BEAT_W-1:0];
			addr_s1  <= wr_addr_q;
			slot_s1  <= SLOT_LUT[wr_addr_q];
			last_s1  <= end_x && end_y && end_f && end_i;
		end
	end

	// two-state sequencer: read, then write back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (beat_acc) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					if (wb_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// read at accept, written back later in the write-back state, so no overlap on an entry
	sast_ram #(
		.WIDTH(WORD_W),
		.DEPTH(STORE_ENTRIES)
	) u_store (
		.clk  (clk),
		.we   (wb_go),
		.waddr(slot_s1),
		.wdata(wr_word),
		.re   (beat_acc),
		.raddr(SLOT_LUT[wr_addr_q]),
		.rdata(rd_word)
	);

	// an entry never written since reset reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wb_go) begin
			valid_q[slot_s1] <= 1'b1;
		end
	end

	// per-lane accumulate and saturate; lanes above LANES stay zero
	always_comb begin
		logic [BYTE_W-1:0] old_byte;
		logic [LANE_W-1:0] sum;
		out_word_d = '0;
		wr_word    = '0;
		for (int i = 0; i < LANES; i++) begin
			old_byte = valid_q[slot_s1] ? rd_word[BYTE_W*i +: BYTE_W] : '0;
			sum      = lanes_s1[LANE_W*i +: LANE_W];
			if (acc_mode_q) begin
				sum = sum + {{(LANE_W-BYTE_W){old_byte[BYTE_W-1]}}, old_byte};
			end
			wr_word[BYTE_W*i +: BYTE_W]    = sat_byte(sum);
			out_word_d[BYTE_W*i +: BYTE_W] = sat_byte(sum);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (wb_go) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wb_go) begin
			out_addr_q <= addr_s1;
			out_word_q <= out_word_d;
			out_last_q <= last_s1;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.entry_address = out_addr_q;
	assign result.bytes_0_7     = out_word_q[FIELD_W-1:0];
	assign result.bytes_8_15    = out_word_q[2*FIELD_W-1:FIELD_W];
	assign result.bytes_16_23   = out_word_q[3*FIELD_W-1:2*FIELD_W];
	assign result.bytes_24_31   = out_word_q[4*FIELD_W-1:3*FIELD_W];
	assign result.final_beat    = out_last_q;

endmodule

FILE: hw/rtl/sast_ram.sv
// generic single-write, single-read ram with registered read data
// depends on nothing
module sast_ram #(
	parameter int unsigned WIDTH = 256,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/sast_checker.sv
// port-level checker for the strided saturating accumulate store, bound to the top level
// depends on strided_saturating_accumulate_store_top_assert.svh
`include "strided_saturating_accumulate_store_top_assert.svh"

module sast_checker (
	input logic clk,
	input logic arst_n,
	input logic beat_valid,
	input logic beat_ready,
	input logic result_valid,
	input logic result_ready,
	input logic cfg_ready
);

	// a beat transaction is followed by busy (beat not ready) while the store is read
	`SAST_ASSERT_NEXT(a_busy_after_beat, clk, arst_n, beat_valid && beat_ready, !beat_ready, "beat accepted while previous beat still in the store path")

	// a new result only appears right after the beat port was busy
	`SAST_ASSERT_SAME(a_result_after_busy, clk, arst_n, $rose(result_valid), $past(!beat_ready), "result appeared without a preceding store access")

	// with the output register free, beat ready returns in the next cycle
	`SAST_ASSERT_NEXT(a_no_idle_stall, clk, arst_n, !beat_ready && !result_valid, beat_ready, "write-back stalled with the output register free")

	// a result held against backpressure stays offered
	`SAST_ASSERT_NEXT(a_result_holds, clk, arst_n, result_valid && !result_ready, result_valid, "result withdrawn before its transaction")

	// configuration port never stalls
	`SAST_ASSERT_SAME(a_cfg_ready, clk, arst_n, 1'b1, cfg_ready, "configuration port not ready")

endmodule

bind strided_saturating_accumulate_store_top sast_checker u_sast_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.beat_valid  (beat.valid),
	.beat_ready  (beat.ready),
	.result_valid(result.valid),
	.result_ready(result.ready),
	.cfg_ready   (cfg.ready)
);
